>>> rtl/mbap_pkg.sv
// mbap_pkg: shared types and constants for the memory block access profiler
// no dependencies
`timescale 1ns / 1ps
package mbap_pkg;
   localparam int NUM_BLOCKS_DEF = 64;
   localparam int BLOCK_BYTES_DEF = 65536;
   localparam int MAX_XFER_DEF = 8;
   localparam logic [31:0] TIMESTEP_RESET = 32'd65536;
   localparam logic [39:0] SAT40 = 40'hFF_FFFF_FFFF;

   localparam logic ACT_XFER = 1'b0;
   localparam logic ACT_END = 1'b1;
   localparam logic [1:0] KIND_READ = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;

   // classified request passed from front to back
   typedef struct packed {
      logic        flush;
      logic        upd;
      logic        is_wr;
      logic [39:0] offset;
      logic [21:0] address;
      logic [3:0]  count;
      logic [63:0] payload;
      logic [47:0] stamp;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FSCAN, ST_FRD, ST_FOUT, ST_UBYTE, ST_UWR
   } bstate_type;

   typedef struct packed {
      logic [5:0]  block_index;
      logic [47:0] stamp;
      logic        read_seen;
      logic [39:0] first_read_at;
      logic [39:0] last_read_at;
      logic [39:0] read_bytes;
      logic        write_seen;
      logic [39:0] first_write_at;
      logic [39:0] last_write_at;
      logic [39:0] write_bytes;
      logic [39:0] zero_bytes;
      logic        last;
   } rec_type;

   function automatic logic [39:0] sat_inc(input logic [39:0] v);
      sat_inc = (v == SAT40) ? v : v + 40'd1;
   endfunction
endpackage

>>> rtl/mbap_front.sv
// mbap_front: accepts requests, tracks clock and timestep, classifies them
// depends on mbap_pkg
`timescale 1ns / 1ps
module mbap_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_action,
   input  logic [39:0]          req_log_offset,
   input  logic [21:0]          req_address,
   input  logic [3:0]           req_byte_count,
   input  logic [1:0]           req_kind,
   input  logic [63:0]          req_payload,
   input  logic [15:0]          req_cycles,
   input  logic [31:0]          timestep,
   output logic                 cmd_valid,
   output mbap_pkg::cmd_type    cmd,
   input  logic                 cmd_ready
);
   import mbap_pkg::*;

   logic [47:0] clock_ff, clock_in;
   logic [39:0] start_ff, start_in;
   logic        vld_ff, vld_in;
   cmd_type     cmd_ff, cmd_in;
   logic        acc, hit;
   logic [40:0] lim;

   assign req_full = vld_ff && !cmd_ready;
   assign acc = req_push && !req_full;
   assign lim = {1'b0, start_ff} + {9'd0, timestep};
   assign hit = {1'b0, req_log_offset} >= lim;

   // classify request and advance clock / timestep start
   always_comb begin
      clock_in = clock_ff;
      start_in = start_ff;
      vld_in = vld_ff && !cmd_ready;
      cmd_in = cmd_ff;
      if (acc) begin
         vld_in = 1'b1;
         cmd_in.offset = req_log_offset;
         cmd_in.address = req_address;
         cmd_in.count = (req_byte_count > 4'(MAX_XFER_DEF)) ? 4'(MAX_XFER_DEF)
                                                            : req_byte_count;
         cmd_in.payload = req_payload;
         cmd_in.is_wr = (req_kind == KIND_WRITE);
         cmd_in.stamp = clock_ff;
         if (req_action == ACT_END) begin
            cmd_in.flush = 1'b1;
            cmd_in.upd = 1'b0;
         end else begin
            cmd_in.flush = hit;
            cmd_in.upd = (req_kind == KIND_READ || req_kind == KIND_WRITE)
                         && req_byte_count != 4'd0;
            if (hit) start_in = req_log_offset;
            clock_in = clock_ff + {32'd0, req_cycles};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff <= '0;
         start_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         clock_ff <= clock_in;
         start_ff <= start_in;
         vld_ff <= vld_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = vld_ff;
   assign cmd = cmd_ff;
endmodule

>>> rtl/mbap_back.sv
// mbap_back: per-block statistics memory, flush walker and update engine
// depends on mbap_pkg
`timescale 1ns / 1ps
module mbap_back #(
   parameter int NUM_BLOCKS = mbap_pkg::NUM_BLOCKS_DEF,
   parameter int BLOCK_BYTES = mbap_pkg::BLOCK_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  mbap_pkg::cmd_type    cmd,
   output logic                 cmd_ready,
   output logic                 rec_valid,
   output mbap_pkg::rec_type    rec,
   input  logic                 rec_ready
);
   import mbap_pkg::*;

   localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int SH = $clog2(BLOCK_BYTES);
   localparam logic [26:0] MEM_END = 27'(NUM_BLOCKS * BLOCK_BYTES);

   // record memory: fr, lr, rt, fw, lw, wt, zt
   logic [279:0] mem [NUM_BLOCKS];
   logic [1:0]   dirty_ff [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] written_ff;
   logic [279:0] rd_ff;

   bstate_type st_ff, st_in;
   cmd_type    c_ff;
   logic [BW-1:0] blk_ff, blk_in;
   logic [3:0]    i_ff, i_in;
   logic          o_vld_ff;
   rec_type       o_ff;

   logic [22:0] baddr;
   logic        inmem;
   logic [BW-1:0] bblk;
   logic [BW-1:0] rblk;
   logic        last_blk, more, byte_zero;
   logic [279:0] upd;
   logic        wen, take, dclr;
   logic [39:0] fr, lr, rt, fw, lw, wt, zt;

   assign baddr = {1'b0, c_ff.address} + {19'd0, i_ff};
   assign inmem = {4'd0, baddr} < MEM_END;
   assign bblk = BW'(baddr >> SH);
   assign last_blk = (blk_ff == BW'(NUM_BLOCKS - 1));
   assign byte_zero = (c_ff.payload[{i_ff[2:0], 3'b000} +: 8] == 8'd0);
   assign take = cmd_valid && cmd_ready;

   // any dirty block above current scan point
   always_comb begin
      more = 1'b0;
      for (int b = 0; b < NUM_BLOCKS; b++)
         if (BW'(b) > blk_ff && dirty_ff[b] != 2'b00) more = 1'b1;
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:  if (take) st_in = cmd.flush ? ST_FSCAN : (cmd.upd ? ST_UBYTE : ST_IDLE);
         ST_FSCAN: if (dirty_ff[blk_ff] != 2'b00) st_in = ST_FRD;
                   else if (last_blk) st_in = c_ff.upd ? ST_UBYTE : ST_IDLE;
         ST_FRD:   st_in = ST_FOUT;
         ST_FOUT:  if (!o_vld_ff || rec_ready)
                      st_in = last_blk ? (c_ff.upd ? ST_UBYTE : ST_IDLE) : ST_FSCAN;
         ST_UBYTE: if (!inmem || i_ff >= c_ff.count) st_in = ST_IDLE;
                   else st_in = ST_UWR;
         ST_UWR:   st_in = (i_ff + 4'd1 >= c_ff.count) ? ST_IDLE : ST_UBYTE;
         default:  st_in = ST_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      blk_in = blk_ff;
      i_in = i_ff;
      cmd_ready = (st_ff == ST_IDLE);
      wen = 1'b0;
      dclr = 1'b0;
      rblk = (st_ff == ST_UBYTE) ? bblk : blk_ff;
      unique case (st_ff)
         ST_IDLE:  begin blk_in = '0; i_in = '0; end
         ST_FSCAN: if (dirty_ff[blk_ff] == 2'b00 && !last_blk) blk_in = blk_ff + BW'(1);
         ST_FRD:   ;
         ST_FOUT:  if (!o_vld_ff || rec_ready) begin
                      dclr = 1'b1;
                      if (!last_blk) blk_in = blk_ff + BW'(1);
                   end
         ST_UBYTE: ;
         ST_UWR:   begin wen = 1'b1; i_in = i_ff + 4'd1; end
         default:  ;
      endcase
   end

   // merge of one byte into the block record
   always_comb begin
      {fr, lr, rt, fw, lw, wt, zt} = rd_ff;
      if (c_ff.is_wr) begin
         lw = c_ff.offset;
         wt = sat_inc(wt);
         if (!dirty_ff[blk_ff][1]) fw = c_ff.offset;
         if (byte_zero) zt = sat_inc(zt);
      end else begin
         lr = c_ff.offset;
         rt = sat_inc(rt);
         if (!dirty_ff[blk_ff][0]) fr = c_ff.offset;
      end
      upd = {fr, lr, rt, fw, lw, wt, zt};
   end

   // never-written entries read as zero
   always_ff @(posedge clock) begin
      rd_ff <= written_ff[rblk] ? mem[rblk] : '0;
      if (wen) mem[blk_ff] <= upd;
      if (take) c_ff <= cmd;
      if (st_ff == ST_UBYTE) blk_ff <= bblk;
      else blk_ff <= blk_in;
      i_ff <= i_in;
   end

   // control state, dirty flags and written flags
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         o_vld_ff <= 1'b0;
         written_ff <= '0;
         for (int b = 0; b < NUM_BLOCKS; b++) dirty_ff[b] <= 2'b00;
      end else begin
         st_ff <= st_in;
         if (dclr) begin
            dirty_ff[blk_ff] <= 2'b00;
            o_vld_ff <= 1'b1;
         end else if (rec_ready) begin
            o_vld_ff <= 1'b0;
         end
         if (wen) begin
            dirty_ff[blk_ff] <= dirty_ff[blk_ff] | (c_ff.is_wr ? 2'b10 : 2'b01);
            written_ff[blk_ff] <= 1'b1;
         end
      end
   end

   // record register
   always_ff @(posedge clock) begin
      if (dclr) begin
         o_ff.block_index <= 6'(blk_ff);
         o_ff.stamp <= c_ff.stamp;
         o_ff.read_seen <= dirty_ff[blk_ff][0];
         o_ff.first_read_at <= dirty_ff[blk_ff][0] ? rd_ff[279:240] : '0;
         o_ff.last_read_at <= dirty_ff[blk_ff][0] ? rd_ff[239:200] : '0;
         o_ff.read_bytes <= rd_ff[199:160];
         o_ff.write_seen <= dirty_ff[blk_ff][1];
         o_ff.first_write_at <= dirty_ff[blk_ff][1] ? rd_ff[159:120] : '0;
         o_ff.last_write_at <= dirty_ff[blk_ff][1] ? rd_ff[119:80] : '0;
         o_ff.write_bytes <= rd_ff[79:40];
         o_ff.zero_bytes <= rd_ff[39:0];
         o_ff.last <= last_blk || !more;
      end
   end

   assign rec_valid = o_vld_ff;
   assign rec = o_ff;
endmodule

>>> rtl/memory_block_access_profiler.sv
// memory_block_access_profiler: top level, front classifier and back engine
// depends on mbap_pkg, mbap_front, mbap_back
// a transfer is registered in the front; the back passes ST_UBYTE and ST_UWR per byte
// a flush walks every block; a dirty one also passes ST_FRD and ST_FOUT after ST_FSCAN
// the back takes a new command only in ST_IDLE, once the current flush or update is done
// synchronous active-high reset clears control state, dirty flags, clock and step start
// a per-block written flag, cleared by reset, makes untouched records read as zero
`timescale 1ns / 1ps
module memory_block_access_profiler #(
   parameter int NUM_BLOCKS = mbap_pkg::NUM_BLOCKS_DEF,
   parameter int BLOCK_BYTES = mbap_pkg::BLOCK_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_action,
   input  logic [39:0] req_log_offset,
   input  logic [21:0] req_address,
   input  logic [3:0]  req_byte_count,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_payload,
   input  logic [15:0] req_cycles,
   output logic        empty,
   input  logic        pop,
   output logic [5:0]  rsp_block_index,
   output logic [47:0] rsp_stamp,
   output logic        rsp_read_seen,
   output logic [39:0] rsp_first_read_at,
   output logic [39:0] rsp_last_read_at,
   output logic [39:0] rsp_read_bytes,
   output logic        rsp_write_seen,
   output logic [39:0] rsp_first_write_at,
   output logic [39:0] rsp_last_write_at,
   output logic [39:0] rsp_write_bytes,
   output logic [39:0] rsp_zero_bytes,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   import mbap_pkg::*;

   logic [31:0] tstep_ff;
   logic        cmd_valid, cmd_ready, rec_valid;
   cmd_type     cmd;
   rec_type     rec;

   assign csr_ready = 1'b1;

   // timestep register
   always_ff @(posedge clock) begin
      if (reset) tstep_ff <= TIMESTEP_RESET;
      else if (csr_valid) tstep_ff <= csr_data;
   end

   mbap_front u_front (
      .clock, .reset, .req_push, .req_full, .req_action, .req_log_offset,
      .req_address, .req_byte_count, .req_kind, .req_payload, .req_cycles,
      .timestep(tstep_ff), .cmd_valid, .cmd, .cmd_ready
   );

   mbap_back #(.NUM_BLOCKS(NUM_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES)) u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_ready, .rec_valid, .rec,
      .rec_ready(pop)
   );

   assign empty = !rec_valid;
   assign rsp_block_index = rec.block_index;
   assign rsp_stamp = rec.stamp;
   assign rsp_read_seen = rec.read_seen;
   assign rsp_first_read_at = rec.first_read_at;
   assign rsp_last_read_at = rec.last_read_at;
   assign rsp_read_bytes = rec.read_bytes;
   assign rsp_write_seen = rec.write_seen;
   assign rsp_first_write_at = rec.first_write_at;
   assign rsp_last_write_at = rec.last_write_at;
   assign rsp_write_bytes = rec.write_bytes;
   assign rsp_zero_bytes = rec.zero_bytes;
   assign rsp_last = rec.last;

   // a reported block has at least one side active
   a_seen: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_read_seen || rsp_write_seen)) else $error("record with no side seen");
   // a held record keeps its block index until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> $stable(rsp_block_index)) else $error("record changed");
endmodule
